// ----- rtl/rpu_pkg.sv -----
package rpu_pkg;

  // Default fraction width of the Q formats.
  localparam int FRAC_BITS_DEF = 24;

  // Field widths fixed by the data format.
  localparam int WORD_W     = 32;
  localparam int STEP_W     = 30;
  localparam int ETA_INC_W  = 27;
  localparam int ETA_DEC_W  = 25;
  localparam int DECAY_W    = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  // Product widths of the three multipliers.
  localparam int DECAY_PROD_W  = DECAY_W + 1 + WORD_W;
  localparam int GROW_PROD_W   = STEP_W + ETA_INC_W;
  localparam int SHRINK_PROD_W = STEP_W + ETA_DEC_W;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLAVOUR   = 3'd0,
    CFG_ETA_INC   = 3'd1,
    CFG_ETA_DEC   = 3'd2,
    CFG_DECAY     = 3'd3,
    CFG_ERR_INC   = 3'd4
  } cfg_idx_t;

  // Rprop flavours.
  typedef enum logic [1:0] {
    FLV_RPROP_PLUS   = 2'd0,
    FLV_RPROP_MINUS  = 2'd1,
    FLV_IRPROP_PLUS  = 2'd2,
    FLV_IRPROP_MINUS = 2'd3
  } flavour_t;

  // Register values after reset.
  localparam logic [ETA_INC_W-1:0] ETA_INC_RST = 27'd20132659;
  localparam logic [ETA_DEC_W-1:0] ETA_DEC_RST = 25'd8388608;
  localparam logic [DECAY_W-1:0]   DECAY_RST   = 25'd0;

  typedef struct packed {
    logic signed [WORD_W-1:0] weight_in;
    logic signed [WORD_W-1:0] grad_now;
    logic signed [WORD_W-1:0] grad_before;
    logic        [STEP_W-1:0] step_in;
    logic signed [WORD_W-1:0] delta_before;
  } rpu_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] weight_out;
    logic        [STEP_W-1:0] step_out;
    logic signed [WORD_W-1:0] grad_kept;
    logic signed [WORD_W-1:0] delta_out;
  } rpu_out_t;

  typedef struct packed {
    flavour_t               flavour;
    logic [ETA_INC_W-1:0]   eta_increase;
    logic [ETA_DEC_W-1:0]   eta_decrease;
    logic [DECAY_W-1:0]     decay_rate;
    logic                   error_increased;
  } rpu_cfg_t;

  // Products and operands handed from the multiplier stage to the update stage.
  typedef struct packed {
    logic signed [DECAY_PROD_W-1:0] decay_prod;
    logic        [GROW_PROD_W-1:0]  grow_prod;
    logic        [SHRINK_PROD_W-1:0] shrink_prod;
    logic                           same_sign;
    logic                           opp_sign;
    logic signed [WORD_W-1:0]       weight;
    logic signed [WORD_W-1:0]       grad;
    logic signed [WORD_W-1:0]       delta;
    logic        [STEP_W-1:0]       step;
  } rpu_prod_t;

endpackage

// ----- rtl/rpu_cfg_regs.sv -----
module rpu_cfg_regs
  import rpu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output rpu_cfg_t              cfg
);

  rpu_cfg_t cfg_r;

  // Writes are taken whenever the block is out of reset.
  assign cfg_ready = rst_n;
  assign cfg     = cfg_r;

  // Register file; an unknown index leaves every register as it is.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flavour         <= FLV_RPROP_PLUS;
      cfg_r.eta_increase    <= ETA_INC_RST;
      cfg_r.eta_decrease    <= ETA_DEC_RST;
      cfg_r.decay_rate      <= DECAY_RST;
      cfg_r.error_increased <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FLAVOUR: cfg_r.flavour      <= flavour_t'(cfg_data[1:0]);
        CFG_ETA_INC: cfg_r.eta_increase <= cfg_data[ETA_INC_W-1:0];
        CFG_ETA_DEC: cfg_r.eta_decrease <= cfg_data[ETA_DEC_W-1:0];
        CFG_DECAY:   cfg_r.decay_rate   <= cfg_data[DECAY_W-1:0];
        CFG_ERR_INC: cfg_r.error_increased <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/rpu_mult_stage.sv -----
module rpu_mult_stage
  import rpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  rpu_in_t   in_item,
  input  rpu_cfg_t  cfg,
  output logic      prod_valid,
  output rpu_prod_t prod
);

  logic      prod_valid_r;
  rpu_prod_t prod_r;
  rpu_prod_t prod_nxt;
  logic signed [DECAY_W:0] decay_s;
  logic      both_nz;

  // The three products and the gradient sign comparison.
  always_comb begin
    decay_s   = {1'b0, cfg.decay_rate};
    both_nz   = (in_item.grad_now != '0) && (in_item.grad_before != '0);
    prod_nxt.decay_prod  = decay_s * in_item.weight_in;
    prod_nxt.grow_prod   = in_item.step_in * cfg.eta_increase;
    prod_nxt.shrink_prod = in_item.step_in * cfg.eta_decrease;
    prod_nxt.same_sign   = both_nz &&
                           (in_item.grad_now[WORD_W-1] == in_item.grad_before[WORD_W-1]);
    prod_nxt.opp_sign    = both_nz &&
                           (in_item.grad_now[WORD_W-1] != in_item.grad_before[WORD_W-1]);
    prod_nxt.weight      = in_item.weight_in;
    prod_nxt.grad        = in_item.grad_now;
    prod_nxt.delta       = in_item.delta_before;
    prod_nxt.step        = in_item.step_in;
  end

  // Payload register without reset; only the valid flag is cleared.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else begin
      prod_valid_r <= in_valid;
    end
  end

  assign prod_valid = prod_valid_r;
  assign prod       = prod_r;

endmodule

// ----- rtl/rpu_update.sv -----
module rpu_update
  import rpu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      prod_valid,
  input  rpu_prod_t prod,
  input  rpu_cfg_t  cfg,
  output logic      out_valid,
  output rpu_out_t  out_item
);

  localparam int ACC_W = 60;
  localparam int WSUM_W = WORD_W + 3;

  // Step limits: 50.0 capped to the field, and 1e-6 rounded but never zero.
  localparam logic [63:0] STEP_CAP_RAW = 64'd50 << FRAC_BITS;
  localparam logic [63:0] STEP_FIELD   = (64'd1 << STEP_W) - 64'd1;
  localparam logic [63:0] STEP_MAX     = (STEP_CAP_RAW < STEP_FIELD) ? STEP_CAP_RAW
                                                                     : STEP_FIELD;
  localparam logic [63:0] STEP_MIN_RAW = ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] STEP_MIN     = (STEP_MIN_RAW > 64'd0) ? STEP_MIN_RAW : 64'd1;
  localparam logic [GROW_PROD_W:0] STEP_MAX_G = STEP_MAX[GROW_PROD_W:0];
  localparam logic [GROW_PROD_W:0] STEP_MIN_G = STEP_MIN[GROW_PROD_W:0];

  // Rounding offsets for the shift by FRAC_BITS.
  localparam logic signed [ACC_W-1:0] HALF_S = 60'sd1 <<< (FRAC_BITS - 1);
  localparam logic [GROW_PROD_W:0]    HALF_U = {{GROW_PROD_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);

  function automatic logic signed [WORD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if ((v[ACC_W-1:WORD_W-1] == '0) || (v[ACC_W-1:WORD_W-1] == '1)) begin
      r = v[WORD_W-1:0];
    end else begin
      r = {v[ACC_W-1], {(WORD_W-1){~v[ACC_W-1]}}};
    end
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_wsum(input logic signed [WSUM_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if ((v[WSUM_W-1:WORD_W-1] == '0) || (v[WSUM_W-1:WORD_W-1] == '1)) begin
      r = v[WORD_W-1:0];
    end else begin
      r = {v[WSUM_W-1], {(WORD_W-1){~v[WSUM_W-1]}}};
    end
    return r;
  endfunction

  logic signed [ACC_W-1:0]  decay_sum;
  logic signed [ACC_W-1:0]  change0;
  logic [GROW_PROD_W:0]     grow_sum;
  logic [GROW_PROD_W:0]     grown;
  logic [GROW_PROD_W:0]     shrink_sum;
  logic [GROW_PROD_W:0]     shrunk;
  logic [GROW_PROD_W:0]     shrunk_min;
  logic [STEP_W-1:0]        grown_clip;
  logic [STEP_W-1:0]        shrunk_clip;
  logic [STEP_W-1:0]        step_new;
  logic signed [WORD_W-1:0] grad_new;
  logic signed [ACC_W-1:0]  step_ext;
  logic signed [ACC_W-1:0]  change_full;
  logic signed [WORD_W-1:0] change;
  logic                     backtrack;
  logic                     add_change;
  logic signed [WSUM_W-1:0] wsum;
  logic signed [WSUM_W-1:0] w_ext;
  logic signed [WSUM_W-1:0] d_ext;
  logic signed [WSUM_W-1:0] c_ext;
  rpu_out_t                 out_nxt;
  rpu_out_t                 out_r;
  logic                     out_valid_r;

  // Rounded decay term and the grown and shrunk step sizes.
  always_comb begin
    decay_sum  = ACC_W'(prod.decay_prod) + HALF_S;
    change0    = -(decay_sum >>> FRAC_BITS);
    grow_sum   = {1'b0, prod.grow_prod} + HALF_U;
    grown      = grow_sum >> FRAC_BITS;
    grown_clip = (grown < STEP_MAX_G) ? grown[STEP_W-1:0] : STEP_MAX_G[STEP_W-1:0];
    shrink_sum = (GROW_PROD_W + 1)'(prod.shrink_prod) + HALF_U;
    shrunk     = shrink_sum >> FRAC_BITS;
    shrunk_min = (shrunk < STEP_MIN_G) ? STEP_MIN_G : shrunk;
    shrunk_clip = (shrunk_min < STEP_MAX_G) ? shrunk_min[STEP_W-1:0]
                                            : STEP_MAX_G[STEP_W-1:0];
  end

  // Flavour decisions: new step, kept gradient, backtracking and weight update.
  always_comb begin
    step_new   = prod.step;
    grad_new   = prod.grad;
    backtrack  = 1'b0;
    add_change = 1'b1;
    if (prod.same_sign) begin
      step_new = grown_clip;
    end else if (prod.opp_sign) begin
      step_new  = shrunk_clip;
      backtrack = (cfg.flavour == FLV_RPROP_PLUS) ||
                  ((cfg.flavour == FLV_IRPROP_PLUS) && cfg.error_increased);
      if (cfg.flavour != FLV_RPROP_MINUS) begin
        grad_new = '0;
      end
      add_change = (cfg.flavour == FLV_RPROP_MINUS) || (cfg.flavour == FLV_IRPROP_MINUS);
    end

    // The sign step; a zeroed gradient leaves only the decay term.
    step_ext = ACC_W'(step_new);
    if (grad_new == '0) begin
      change_full = change0;
    end else if (grad_new[WORD_W-1]) begin
      change_full = change0 + step_ext;
    end else begin
      change_full = change0 - step_ext;
    end
    change = sat_acc(change_full);

    w_ext = WSUM_W'(prod.weight);
    d_ext = backtrack  ? WSUM_W'(prod.delta) : '0;
    c_ext = add_change ? WSUM_W'(change)     : '0;
    wsum  = w_ext - d_ext + c_ext;

    out_nxt.weight_out = sat_wsum(wsum);
    out_nxt.step_out   = step_new;
    out_nxt.grad_kept  = grad_new;
    out_nxt.delta_out  = change;
  end

  // Result register; the strobe follows the operand valid in the next cycle.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= prod_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- rtl/rprop_weight_update.sv -----
// Rprop weight update, one weight element per transaction.
//
// Input: drive in_data and raise start; the transaction is taken at a rising
// edge where start is high and busy is low. busy is high only while rst_n is
// low, so a new element may be issued in every cycle.
// Output: each result appears on out_data for exactly one cycle with
// out_valid high. The receiver cannot stall; results must be taken as shown.
// Pipeline: a taken transaction is registered in the input register, then in
// the multiplier register, then in the result register before it is on the
// outputs. Throughput is one element per cycle, these three registers forming
// a three-stage pipeline.
// Configuration: registers are written through the cfg_ channel (index in
// list order); cfg_ready is high out of reset. Write only while no element
// is in flight. Unknown indexes are ignored.
// Reset (synchronous, active low) empties the pipeline and restores the
// register defaults: RPROP+, increase 1.2, decrease 0.5, no decay.
module rprop_weight_update
  import rpu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rpu_in_t               in_data,
  output logic                  out_valid,
  output rpu_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rpu_cfg_t  cfg;
  rpu_in_t   in_r;
  logic      in_valid_r;
  logic      in_accept;
  logic      prod_valid;
  rpu_prod_t prod;

  assign busy      = !rst_n;
  assign in_accept = start && !busy;

  rpu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    in_r <= in_data;
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_accept;
    end
  end

  rpu_mult_stage u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid_r),
    .in_item    (in_r),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  rpu_update #(
    .FRAC_BITS (FRAC_BITS)
  ) u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_valid (prod_valid),
    .prod       (prod),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_item   (out_data)
  );

  // Every accepted transaction shows up on out_valid after the pipeline registers.
  a_accept_to_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##3 out_valid)
    else $error("accepted transaction produced no result");

  // No result without a transaction accepted before it into the pipeline.
  a_result_has_source : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, 3))
    else $error("result without a matching transaction");

  // RPROP- never zeroes the gradient.
  a_minus_keeps_grad : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (cfg.flavour == FLV_RPROP_MINUS)) |->
      (out_data.grad_kept == $past(in_r.grad_now, 2)))
    else $error("gradient altered in RPROP- mode");

endmodule
